/* rtl/qrv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_pkg - shared types and constants for the quaternion point rotator
// Fixed-point widths of the quaternion, the matrix entries, the coordinate
// products and the accumulators, plus the register index map.
// ----------------------------------------------------------------------------
package qrv_pkg;

	// Base formats
	localparam int COORD_WIDTH    = 32;
	localparam int QUAT_FRAC_BITS = 14;
	localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;

	// Quaternion component products (exact, 2F fraction bits)
	localparam int QPROD_W = 2 * QUAT_WIDTH;
	// Unrounded matrix entry: sums of products, doubled
	localparam int RAW_W   = QPROD_W + 2;
	// Matrix entry after rounding to F fraction bits
	localparam int ENTRY_W = RAW_W - QUAT_FRAC_BITS;
	// Entry times coordinate
	localparam int PROD_W  = ENTRY_W + COORD_WIDTH;
	// Sum of three products
	localparam int ACC_W   = PROD_W + 2;
	// Accumulator after the final rounding shift
	localparam int SHIFT_W = ACC_W - QUAT_FRAC_BITS;

	// Configuration register map
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_QUAT_W       = 3'd0,
		REG_QUAT_X       = 3'd1,
		REG_QUAT_Y       = 3'd2,
		REG_QUAT_Z       = 3'd3,
		REG_GENERAL_MODE = 3'd4
	} cfg_reg_t;

	typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [ENTRY_W-1:0]     entry_t;
	typedef logic signed [QPROD_W-1:0]     qprod_t;
	typedef logic signed [RAW_W-1:0]       raw_t;

	// 1.0 in the quaternion format
	localparam quat_t QUAT_ONE = quat_t'(QUAT_WIDTH'(1) << QUAT_FRAC_BITS);

	// Quaternion and mode as held in the configuration registers
	typedef struct packed {
		quat_t w;
		quat_t x;
		quat_t y;
		quat_t z;
		logic  general_mode;
	} quat_cfg_t;

endpackage

/* rtl/qrv_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_matrix - rotation matrix builder, pipeline stages 1 and 2
// Stage 1 registers the ten quaternion component products, stage 2 forms
// the nine matrix entries and rounds them to F fraction bits. The point
// travels alongside so each request carries its own matrix.
// ----------------------------------------------------------------------------
module qrv_matrix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_stall,
	input  qrv_pkg::coord_t     point_x,
	input  qrv_pkg::coord_t     point_y,
	input  qrv_pkg::coord_t     point_z,
	input  qrv_pkg::quat_cfg_t  cfg,
	output logic                dn_valid,
	input  logic                dn_stall,
	output qrv_pkg::entry_t     mat [9],
	output qrv_pkg::coord_t     pnt [3]
);

	localparam int F     = qrv_pkg::QUAT_FRAC_BITS;
	localparam int RAW_W = qrv_pkg::RAW_W;
	localparam int ENT_W = qrv_pkg::ENTRY_W;
	localparam qrv_pkg::raw_t ONE_RAW = qrv_pkg::raw_t'(RAW_W'(1) << (2 * F));
	localparam qrv_pkg::raw_t HALF    = qrv_pkg::raw_t'(RAW_W'(1) << (F - 1));

	// Round half up to F fraction bits
	function automatic qrv_pkg::entry_t round_entry(input qrv_pkg::raw_t v);
		qrv_pkg::raw_t t;
		begin
			t = v + HALF;
			return qrv_pkg::entry_t'(ENT_W'(t >>> F));
		end
	endfunction

	// Stage 1 registers
	logic              v_s1;
	qrv_pkg::qprod_t   ww_s1, aa_s1, bb_s1, cc_s1;
	qrv_pkg::qprod_t   ab_s1, ac_s1, bc_s1;
	qrv_pkg::qprod_t   wa_s1, wb_s1, wc_s1;
	logic              gen_s1;
	qrv_pkg::coord_t   pnt_s1 [3];

	// Stage 2 registers
	logic              v_s2;
	qrv_pkg::entry_t   mat_s2 [9];
	qrv_pkg::coord_t   pnt_s2 [3];

	logic              adv1, adv2;
	qrv_pkg::raw_t     raw [9];
	qrv_pkg::raw_t     e_ww, e_aa, e_bb, e_cc, e_ab, e_ac, e_bc, e_wa, e_wb, e_wc;

	// Advance a stage when it is empty or the next one moves
	assign adv2     = !v_s2 || !dn_stall;
	assign adv1     = !v_s1 || adv2;
	assign up_stall = !adv1;

	// Stage 1: component products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && up_valid) begin
			ww_s1     <= cfg.w * cfg.w;
			aa_s1     <= cfg.x * cfg.x;
			bb_s1     <= cfg.y * cfg.y;
			cc_s1     <= cfg.z * cfg.z;
			ab_s1     <= cfg.x * cfg.y;
			ac_s1     <= cfg.x * cfg.z;
			bc_s1     <= cfg.y * cfg.z;
			wa_s1     <= cfg.w * cfg.x;
			wb_s1     <= cfg.w * cfg.y;
			wc_s1     <= cfg.w * cfg.z;
			gen_s1    <= cfg.general_mode;
			pnt_s1[0] <= point_x;
			pnt_s1[1] <= point_y;
			pnt_s1[2] <= point_z;
		end
	end

	// Widen the products to the entry accumulation width
	always_comb begin
		e_ww = qrv_pkg::raw_t'(ww_s1);
		e_aa = qrv_pkg::raw_t'(aa_s1);
		e_bb = qrv_pkg::raw_t'(bb_s1);
		e_cc = qrv_pkg::raw_t'(cc_s1);
		e_ab = qrv_pkg::raw_t'(ab_s1);
		e_ac = qrv_pkg::raw_t'(ac_s1);
		e_bc = qrv_pkg::raw_t'(bc_s1);
		e_wa = qrv_pkg::raw_t'(wa_s1);
		e_wb = qrv_pkg::raw_t'(wb_s1);
		e_wc = qrv_pkg::raw_t'(wc_s1);
	end

	// Matrix entries, row major, 2F fraction bits
	always_comb begin
		if (gen_s1) begin
			raw[0] = e_ww + e_aa - e_bb - e_cc;
			raw[4] = e_ww + e_bb - e_aa - e_cc;
			raw[8] = e_ww + e_cc - e_aa - e_bb;
		end else begin
			raw[0] = ONE_RAW - (e_bb <<< 1) - (e_cc <<< 1);
			raw[4] = ONE_RAW - (e_aa <<< 1) - (e_cc <<< 1);
			raw[8] = ONE_RAW - (e_aa <<< 1) - (e_bb <<< 1);
		end
		raw[1] = (e_ab - e_wc) <<< 1;
		raw[2] = (e_ac + e_wb) <<< 1;
		raw[3] = (e_ab + e_wc) <<< 1;
		raw[5] = (e_bc - e_wa) <<< 1;
		raw[6] = (e_ac - e_wb) <<< 1;
		raw[7] = (e_bc + e_wa) <<< 1;
	end

	// Stage 2: rounded entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			for (int k = 0; k < 9; k++) begin
				mat_s2[k] <= round_entry(raw[k]);
			end
			for (int k = 0; k < 3; k++) begin
				pnt_s2[k] <= pnt_s1[k];
			end
		end
	end

	assign dn_valid = v_s2;
	assign mat      = mat_s2;
	assign pnt      = pnt_s2;

endmodule

/* rtl/qrv_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_mac - matrix times point, pipeline stages 3 and 4
// Stage 3 registers the nine entry-coordinate products, stage 4 sums each
// row, rounds to Q16.16 and clips to the coordinate range. Stage 4 is the
// output register.
// ----------------------------------------------------------------------------
module qrv_mac (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_stall,
	input  qrv_pkg::entry_t  mat [9],
	input  qrv_pkg::coord_t  pnt [3],
	output logic             dn_valid,
	input  logic             dn_stall,
	output qrv_pkg::coord_t  rot [3],
	output logic             sat
);

	localparam int F      = qrv_pkg::QUAT_FRAC_BITS;
	localparam int CW     = qrv_pkg::COORD_WIDTH;
	localparam int PROD_W = qrv_pkg::PROD_W;
	localparam int ACC_W  = qrv_pkg::ACC_W;
	localparam int SH_W   = qrv_pkg::SHIFT_W;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);
	localparam logic [CW-1:0] CMAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] CMIN = {1'b1, {(CW - 1){1'b0}}};

	// Stage 3 registers
	logic                       v_s3;
	logic signed [PROD_W-1:0]   prod_s3 [9];

	// Stage 4 registers
	logic                       v_s4;
	qrv_pkg::coord_t            rot_s4 [3];
	logic                       sat_s4;

	logic                       adv3, adv4;
	logic signed [ACC_W-1:0]    acc [3];
	logic signed [SH_W-1:0]     shr [3];
	logic [2:0]                 clip;
	qrv_pkg::coord_t            res [3];

	assign adv4     = !v_s4 || !dn_stall;
	assign adv3     = !v_s3 || adv4;
	assign up_stall = !adv3;

	// Stage 3: entry times coordinate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && up_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s3[i * 3 + j] <= PROD_W'(mat[i * 3 + j]) * PROD_W'(pnt[j]);
				end
			end
		end
	end

	// Row sums, rounding shift and clipping
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'(prod_s3[i * 3]) + ACC_W'(prod_s3[i * 3 + 1])
				+ ACC_W'(prod_s3[i * 3 + 2]) + HALF;
			shr[i] = SH_W'(acc[i] >>> F);
			// out of range when the bits above the sign are not all copies of it
			clip[i] = (shr[i][SH_W-1:CW-1] != {(SH_W - CW + 1){1'b0}})
				&& (shr[i][SH_W-1:CW-1] != {(SH_W - CW + 1){1'b1}});
			if (clip[i]) begin
				res[i] = shr[i][SH_W-1] ? qrv_pkg::coord_t'(CMIN) : qrv_pkg::coord_t'(CMAX);
			end else begin
				res[i] = qrv_pkg::coord_t'(shr[i][CW-1:0]);
			end
		end
	end

	// Stage 4: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				rot_s4[i] <= res[i];
			end
			sat_s4 <= |clip;
		end
	end

	assign dn_valid = v_s4;
	assign rot      = rot_s4;
	assign sat      = sat_s4;

endmodule

/* rtl/quaternion_rotate_vector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_vector - rotate Q16.16 points by a Q1.14 quaternion
// Builds the rotation matrix from the configured quaternion and multiplies
// each incoming point by it, with rounding and saturation.
//
//   Channel   Signals                                  Direction
//   input     in_valid, in_stall, point_x/y/z          request in
//   output    out_valid, out_stall, rotated_x/y/z,     request out
//             saturated
//   config    cfg_valid, cfg_ready, cfg_index,         register write in
//             cfg_data
//
// One point per clock while out_stall is low; a point passes the product,
// entry, multiply and sum/clip stages in that order.
// Reset loads the identity quaternion in unit mode and empties the pipe.
// A stall on the output holds stage 4; earlier stages keep filling their
// empty slots, so in_stall rises only when every stage holds a request.
// Configuration writes are always ready and take effect on the next point.
// ----------------------------------------------------------------------------
module quaternion_rotate_vector (
	input  logic                                clk,
	input  logic                                arst_n,
	// point input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  qrv_pkg::coord_t                     point_x,
	input  qrv_pkg::coord_t                     point_y,
	input  qrv_pkg::coord_t                     point_z,
	// rotated output
	output logic                                out_valid,
	input  logic                                out_stall,
	output qrv_pkg::coord_t                     rotated_x,
	output qrv_pkg::coord_t                     rotated_y,
	output qrv_pkg::coord_t                     rotated_z,
	output logic                                saturated,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qrv_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [qrv_pkg::QUAT_WIDTH-1:0]      cfg_data
);

	qrv_pkg::quat_cfg_t  cfg_q;
	logic                mid_valid;
	logic                mid_stall;
	qrv_pkg::entry_t     mat [9];
	qrv_pkg::coord_t     pnt [3];
	qrv_pkg::coord_t     rot [3];

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.w            <= qrv_pkg::QUAT_ONE;
			cfg_q.x            <= '0;
			cfg_q.y            <= '0;
			cfg_q.z            <= '0;
			cfg_q.general_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qrv_pkg::REG_QUAT_W:       cfg_q.w <= qrv_pkg::quat_t'(cfg_data);
				qrv_pkg::REG_QUAT_X:       cfg_q.x <= qrv_pkg::quat_t'(cfg_data);
				qrv_pkg::REG_QUAT_Y:       cfg_q.y <= qrv_pkg::quat_t'(cfg_data);
				qrv_pkg::REG_QUAT_Z:       cfg_q.z <= qrv_pkg::quat_t'(cfg_data);
				qrv_pkg::REG_GENERAL_MODE: cfg_q.general_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Matrix build stages
	qrv_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_stall (in_stall),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.cfg      (cfg_q),
		.dn_valid (mid_valid),
		.dn_stall (mid_stall),
		.mat      (mat),
		.pnt      (pnt)
	);

	// Multiply, sum and clip stages
	qrv_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mid_valid),
		.up_stall (mid_stall),
		.mat      (mat),
		.pnt      (pnt),
		.dn_valid (out_valid),
		.dn_stall (out_stall),
		.rot      (rot),
		.sat      (saturated)
	);

	assign rotated_x = rot[0];
	assign rotated_y = rot[1];
	assign rotated_z = rot[2];

endmodule
